/* rtl/core/swp_pkg.sv */
// Package for the sliding window product block: sizes, float constants,
// sequencer state type, register indices and the float product type. No dependencies.
package swp_pkg;

  localparam int MAX_WINDOW_DEF = 8;
  localparam int MAX_COLS_DEF   = 1024;
  localparam int MAX_ROWS_DEF   = 1024;

  localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN  = 32'h7FC0_0000;
  localparam logic [31:0] FP_ZERO  = 32'h0000_0000;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_ROWS   = 2'd1;
  localparam logic [1:0] REG_COLS   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_MUL,
    ST_NORM,
    ST_OUT
  } state_t;

  // Product of two unpacked operands ahead of rounding.
  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic signed [10:0] exp;   // unbiased exponent of bit 47 of mant
    logic [47:0] mant;
  } fp_prod_t;

endpackage

/* rtl/core/swp_if.sv */
// Valid/ready channel interface carrying a payload of parameterized type.
// Depends on nothing.
interface swp_if #(parameter type payload_t = logic [31:0]) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/swp_fmul.sv */
// Shared single precision multiplier, two stages: mantissa product, then
// normalize and round to nearest even. Depends on swp_pkg.
module swp_fmul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  swp_pkg::fp_prod_t prod;
  swp_pkg::fp_prod_t stage;

  // Stage one: unpack and multiply mantissas.
  always_comb begin
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [23:0] ma, mb;
    logic signed [10:0] xa, xb;
    logic [4:0]  za, zb;
    ea = a[30:23]; eb = b[30:23];
    fa = a[22:0];  fb = b[22:0];
    za = 5'd0; zb = 5'd0;
    // Subnormals are normalized here so each mantissa has its top bit high.
    ma = (ea == 8'd0) ? {1'b0, fa} : {1'b1, fa};
    mb = (eb == 8'd0) ? {1'b0, fb} : {1'b1, fb};
    for (int i = 23; i >= 0; i--) begin
      if (ma[i] && za == 5'd0 && ma[23:0] >> (i + 1) == 24'd0) za = 5'(23 - i);
      if (mb[i] && zb == 5'd0 && mb[23:0] >> (i + 1) == 24'd0) zb = 5'(23 - i);
    end
    ma = ma << za;
    mb = mb << zb;
    xa = (ea == 8'd0) ? 11'sd1 - 11'sd127 - $signed({6'd0, za})
                      : $signed({3'd0, ea}) - 11'sd127;
    xb = (eb == 8'd0) ? 11'sd1 - 11'sd127 - $signed({6'd0, zb})
                      : $signed({3'd0, eb}) - 11'sd127;
    prod.sign    = a[31] ^ b[31];
    prod.is_nan  = (ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0) ||
                   (ea == 8'hFF && b[30:0] == 31'd0) || (eb == 8'hFF && a[30:0] == 31'd0);
    prod.is_inf  = (ea == 8'hFF) || (eb == 8'hFF);
    prod.is_zero = (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
    prod.exp     = xa + xb + 11'sd1;
    prod.mant    = ma * mb;
  end

  always_ff @(posedge clk) begin
    stage <= prod;
  end

  // Stage two: normalize, denormalize below range, round to nearest even.
  always_comb begin
    logic [47:0] m;
    logic signed [10:0] e;
    logic signed [10:0] be;
    logic [5:0]  sh;
    logic [24:0] keep;
    logic        g, st;
    logic [25:0] rnd;
    m = stage.mant;
    e = stage.exp;
    if (!m[47]) begin
      m = m << 1;
      e = e - 11'sd1;
    end
    be = e + 11'sd127;
    sh = 6'd0;
    if (be < 11'sd1) begin
      sh = (be < -11'sd30) ? 6'd32 : 6'(11'sd1 - be);
      be = 11'sd0;
    end
    // keep: 24 significant bits after the shift; guard and sticky below.
    // Past a shift of 24 the guard position lies above the product.
    keep = 25'({1'b0, m[47:24]} >> sh);
    g    = (sh > 6'd24) ? 1'b0 : m[6'd23 + sh];
    st   = 1'b0;
    for (int i = 0; i < 48; i++)
      if (i < 23 + int'(sh)) st = st | m[i];
    rnd = {1'b0, keep} + ((g && (st || keep[0])) ? 26'd1 : 26'd0);
    if (be == 11'sd0) begin
      // Subnormal path: carry into bit 23 makes it the smallest normal.
      be  = rnd[23] ? 11'sd1 : 11'sd0;
    end else if (rnd[24]) begin
      rnd = rnd >> 1;
      be  = be + 11'sd1;
    end
    if (stage.is_nan)
      y = swp_pkg::FP_QNAN;
    else if (stage.is_inf)
      y = {stage.sign, 8'hFF, 23'd0};
    else if (stage.is_zero)
      y = {stage.sign, 31'd0};
    else if (be >= 11'sd255)
      y = {stage.sign, 8'hFF, 23'd0};
    else
      y = {stage.sign, be[7:0], rnd[22:0]};
  end

endmodule

/* rtl/core/swp_seq.sv */
// Window sequencer: position tracking, line store, and the loop that feeds
// the shared multiplier. Depends on swp_pkg and swp_fmul.
module swp_seq #(
  parameter int MAX_WINDOW = swp_pkg::MAX_WINDOW_DEF,
  parameter int MAX_COLS   = swp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = swp_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_element,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_product,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        out_last
);

  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  // Rows are kept in a power of two of slots, at least MAX_WINDOW of them.
  localparam int SLOTS = 1 << SW;
  localparam int DEPTH = SLOTS * MAX_COLS;
  localparam int MW = $clog2(DEPTH);

  // Registers, raw as written.
  logic [3:0]  window_size;
  logic [10:0] num_rows, num_cols;
  logic [RW-1:0] row_position;
  logic [CW-1:0] col_position;

  // Clamped register values.
  logic [WW-1:0] k;
  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  always_comb begin
    k    = (window_size == 4'd0) ? WW'(1) :
           (32'(window_size) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(window_size);
    rows = (num_rows == 11'd0) ? RW'(1) :
           (32'(num_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(num_rows);
    cols = (num_cols == 11'd0) ? CW'(1) :
           (32'(num_cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(num_cols);
  end

  // Line store.
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data;
  logic        mem_we;
  logic [MW-1:0] wr_addr, rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= in_element;
    rd_data <= mem[rd_addr];
  end

  // Shared multiplier.
  logic [31:0] acc, mul_y;
  swp_fmul u_fmul (.clk(clk), .a(acc), .b(rd_data), .y(mul_y));

  // Sequencer state.
  swp_pkg::state_t state, state_next;
  logic [RW-1:0] top;
  logic [CW-1:0] left;
  logic [WW-1:0] wi, wj;
  logic          cur_last;
  logic [RW-1:0] r_eff;
  logic [CW-1:0] c_eff;
  logic          oversize, complete;

  always_comb begin
    if (row_position >= rows || col_position >= cols) begin
      r_eff = '0;
      c_eff = '0;
    end else begin
      r_eff = row_position;
      c_eff = col_position;
    end
    oversize = (32'(k) > 32'(rows)) || (32'(k) > 32'(cols));
    complete = (r_eff >= RW'(k - WW'(1))) && (c_eff >= CW'(k - WW'(1)));
  end

  // Store addresses: the row slot is the row index modulo the slot count.
  logic [SW-1:0] slot_w, slot_r;
  always_comb begin
    slot_w  = SW'(r_eff);
    slot_r  = SW'(top + RW'(wi));
    wr_addr = MW'(slot_w) * MW'(MAX_COLS) + MW'(c_eff);
    rd_addr = MW'(slot_r) * MW'(MAX_COLS) + MW'(left + CW'(wj));
    mem_we  = in_valid && in_ready;
  end

  assign in_ready = (state == swp_pkg::ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      swp_pkg::ST_IDLE:
        if (in_valid && in_ready && !oversize && complete)
          state_next = swp_pkg::ST_READ;
      swp_pkg::ST_READ: state_next = swp_pkg::ST_WAIT;
      swp_pkg::ST_WAIT: state_next = swp_pkg::ST_MUL;
      swp_pkg::ST_MUL:  state_next = swp_pkg::ST_NORM;
      swp_pkg::ST_NORM:
        if (wi == k - WW'(1) && wj == k - WW'(1)) state_next = swp_pkg::ST_OUT;
        else state_next = swp_pkg::ST_READ;
      swp_pkg::ST_OUT:  state_next = swp_pkg::ST_IDLE;
      default:          state_next = swp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= swp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Datapath and position control.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= 4'd3;
      num_rows     <= 11'd1024;
      num_cols     <= 11'd1024;
      row_position <= '0;
      col_position <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we && cfg_index inside {swp_pkg::REG_WINDOW, swp_pkg::REG_ROWS,
                                      swp_pkg::REG_COLS}) begin
        case (cfg_index)
          swp_pkg::REG_WINDOW: window_size <= cfg_data[3:0];
          swp_pkg::REG_ROWS:   num_rows    <= cfg_data;
          swp_pkg::REG_COLS:   num_cols    <= cfg_data;
          default: ;
        endcase
        row_position <= '0;
        col_position <= '0;
      end else if (in_valid && in_ready) begin
        if (c_eff + CW'(1) >= cols) begin
          col_position <= '0;
          row_position <= (r_eff + RW'(1) >= rows) ? '0 : r_eff + RW'(1);
        end else begin
          col_position <= c_eff + CW'(1);
          row_position <= r_eff;
        end
      end
      if (state == swp_pkg::ST_IDLE && in_valid && in_ready) begin
        cur_last <= (r_eff == rows - RW'(1)) && (c_eff == cols - CW'(1));
        top      <= r_eff - RW'(k - WW'(1));
        left     <= c_eff - CW'(k - WW'(1));
        wi       <= '0;
        wj       <= '0;
        acc      <= swp_pkg::FP_ONE;
        if (oversize) begin
          out_valid   <= 1'b1;
          out_product <= swp_pkg::FP_ZERO;
          out_row     <= 10'(r_eff);
          out_col     <= 10'(c_eff);
          out_last    <= (r_eff == rows - RW'(1)) && (c_eff == cols - CW'(1));
        end
      end
      if (state == swp_pkg::ST_NORM) begin
        acc <= mul_y;
        if (wj == k - WW'(1)) begin
          wj <= '0;
          wi <= wi + WW'(1);
        end else begin
          wj <= wj + WW'(1);
        end
      end
      if (state == swp_pkg::ST_OUT) begin
        out_valid   <= 1'b1;
        out_product <= (acc[30:23] == 8'hFF && acc[22:0] != 23'd0) ? swp_pkg::FP_QNAN : acc;
        out_row     <= 10'(top);
        out_col     <= 10'(left);
        out_last    <= cur_last;
      end
    end
  end

endmodule

/* rtl/core/sliding_window_product.sv */
// Sliding window product, top level: channel interfaces and config port.
// Window elements pass the read, wait, multiply and normalize states, then out.
// Throughput: one request at a time; a result must be taken before the next
// request, set by the shared two-stage float multiplier loop.
// No-window results skip the multiplier. Reset (synchronous, rst high) clears
// positions and restores window 3, 1024 rows, 1024 columns; no store clearing.
module sliding_window_product #(
  parameter int MAX_WINDOW = swp_pkg::MAX_WINDOW_DEF,
  parameter int MAX_COLS   = swp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = swp_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic [31:0] element,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [31:0] product,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        last,
  output logic        out_valid,
  input  logic        out_ready
);

  swp_seq #(.MAX_WINDOW(MAX_WINDOW), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_seq (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_element(element),
    .out_valid(out_valid), .out_ready(out_ready), .out_product(product),
    .out_row(out_row), .out_col(out_col), .out_last(last)
  );

endmodule

/* dv/swp_tb_checker.sv */
`timescale 1ns / 100ps
// Checker for the sliding window product: follows the config port and both
// channels, predicts every window product and compares results in order.
// Depends on swp_pkg and the swp_if channel interface.
module swp_tb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  swp_if              req_ch,
  swp_if              res_ch,
  output int          errors,
  output int          pending
);
  import swp_pkg::*;

  localparam int WIN_MAX  = MAX_WINDOW_DEF;
  localparam int COLS_MAX = MAX_COLS_DEF;
  localparam int ROWS_MAX = MAX_ROWS_DEF;

  typedef struct packed {
    logic [31:0] product;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
  } window_result_t;

  logic [31:0] line_copy [WIN_MAX*COLS_MAX];
  logic [3:0]  win_reg;
  logic [10:0] rows_reg;
  logic [10:0] cols_reg;
  int          cur_row;
  int          cur_col;
  window_result_t expected_q[$];

  initial errors = 0;
  initial pending = 0;

  // Single precision multiply, round to nearest even, subnormals kept.
  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic        s;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic [95:0] wide;
    logic [24:0] q;
    logic        guard, sticky, a_inf, b_inf, a_zero, b_zero;
    int          ua, ub, lead, e, e_eff, sh;
    s = a[31] ^ b[31];
    ea = a[30:23];
    eb = b[30:23];
    if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) return FP_QNAN;
    a_inf = (ea == 8'hFF);
    b_inf = (eb == 8'hFF);
    a_zero = (a[30:0] == 0);
    b_zero = (b[30:0] == 0);
    if ((a_inf && b_zero) || (b_inf && a_zero)) return FP_QNAN;
    if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
    if (a_zero || b_zero) return {s, 31'd0};
    ma = {ea != 0, a[22:0]};
    mb = {eb != 0, b[22:0]};
    ua = (ea == 0) ? -126 : int'(ea) - 127;
    ub = (eb == 0) ? -126 : int'(eb) - 127;
    p = ma * mb;
    lead = 0;
    for (int i = 0; i < 48; i++) if (p[i]) lead = i;
    e = ua + ub - 46 + lead;
    if (e > 127) return {s, 8'hFF, 23'd0};
    e_eff = (e < -126) ? -126 : e;
    sh = (e_eff - 23) - (ua + ub - 46);
    if (sh <= 0) begin
      q = 25'(p << (-sh));
      guard = 1'b0;
      sticky = 1'b0;
    end else if (sh >= 49) begin
      q = '0;
      guard = 1'b0;
      sticky = 1'b1;
    end else begin
      wide = {48'd0, p};
      q = 25'(wide >> sh);
      guard = wide[sh-1];
      sticky = (wide & ((96'd1 << (sh - 1)) - 96'd1)) != 0;
    end
    if (guard && (sticky || q[0])) q = q + 25'd1;
    if (q[24]) begin
      q = q >> 1;
      e_eff++;
    end
    if (e_eff > 127) return {s, 8'hFF, 23'd0};
    if (!q[23]) return {s, 8'd0, q[22:0]};
    return {s, 8'(e_eff + 127), q[22:0]};
  endfunction

  function automatic int clamp_size(int v, int top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // Store one element and queue the result that it completes, if any (zero for an oversized window).
  function automatic void take_element(logic [31:0] x);
    int k, rows, cols, r, c, top_row, left_col, base;
    logic is_last;
    logic [31:0] acc;
    k = clamp_size(win_reg, WIN_MAX);
    rows = clamp_size(rows_reg, ROWS_MAX);
    cols = clamp_size(cols_reg, COLS_MAX);
    r = cur_row;
    c = cur_col;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    is_last = (r == rows - 1) && (c == cols - 1);
    line_copy[(r % WIN_MAX) * COLS_MAX + c] = x;
    if (k > rows || k > cols) begin
      expected_q.push_back({FP_ZERO, 10'(r), 10'(c), is_last});
    end else if (r >= k - 1 && c >= k - 1) begin
      top_row = r - (k - 1);
      left_col = c - (k - 1);
      acc = FP_ONE;
      for (int i = 0; i < k; i++) begin
        base = ((top_row + i) % WIN_MAX) * COLS_MAX;
        for (int j = 0; j < k; j++) acc = fp_mul(acc, line_copy[base + left_col + j]);
      end
      expected_q.push_back({acc, 10'(top_row), 10'(left_col), is_last});
    end
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endfunction

  // Follow config writes and requests, then check each accepted result.
  always @(posedge clk) begin
    window_result_t got, exp_res;
    if (rst) begin
      win_reg = 4'd3;
      rows_reg = 11'd1024;
      cols_reg = 11'd1024;
      cur_row = 0;
      cur_col = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: win_reg = cfg_data[3:0];
          REG_ROWS:   rows_reg = cfg_data;
          REG_COLS:   cols_reg = cfg_data;
          default: ;
        endcase
        if (cfg_index == REG_WINDOW || cfg_index == REG_ROWS || cfg_index == REG_COLS) begin
          cur_row = 0;
          cur_col = 0;
        end
      end
      if (req_ch.valid && req_ch.ready) take_element(req_ch.payload);
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.payload;
        if (expected_q.size() == 0) begin
          $error("unexpected result: product %h row %0d col %0d", got.product, got.row,
                 got.col);
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (got.product !== exp_res.product) begin
            $error("product: expected %h, actual %h", exp_res.product, got.product);
            errors++;
          end
          if (got.row !== exp_res.row) begin
            $error("out_row: expected %0d, actual %0d", exp_res.row, got.row);
            errors++;
          end
          if (got.col !== exp_res.col) begin
            $error("out_col: expected %0d, actual %0d", exp_res.col, got.col);
            errors++;
          end
          if (got.last !== exp_res.last) begin
            $error("last: expected %0b, actual %0b", exp_res.last, got.last);
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* dv/tb_sliding_window_product.sv */
`timescale 1ns / 100ps
// Top of the sliding window product testbench: clock, reset, stimulus and
// verdict. Depends on swp_pkg, swp_if, swp_tb_checker and the block itself.
module tb_sliding_window_product;
  import swp_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int CALM_AFTER  = 1250;
  localparam int SETTLE      = 300;
  localparam int QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_WINDOW;
  logic [10:0] cfg_data = '0;
  logic [31:0] product;
  logic [9:0]  out_row;
  logic [9:0]  out_col;
  logic        last;
  logic        out_valid;
  int          errors;
  int          pending;
  int          sent = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          stall_mode = 1'b1;
  bit          gap_mode = 1'b1;
  bit          drained_once = 1'b0;

  swp_if #(.payload_t(logic [31:0])) req_ch (clk);
  swp_if #(.payload_t(logic [52:0])) res_ch (clk);

  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    res_ch.ready = 1'b1;
  end

  always #10 clk = ~clk;

  sliding_window_product dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .element(req_ch.payload), .in_valid(req_ch.valid), .in_ready(req_ch.ready),
    .product(product), .out_row(out_row), .out_col(out_col), .last(last),
    .out_valid(out_valid), .out_ready(res_ch.ready)
  );

  assign res_ch.valid = out_valid;
  assign res_ch.payload = {product, out_row, out_col, last};

  swp_tb_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_ch(req_ch), .res_ch(res_ch), .errors(errors), .pending(pending)
  );

  // Result side stalls in random bursts while stall mode is on and the run is not calm.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (!calm && stall_mode && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(1, 11) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Give up when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_sliding_window_product NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly values near one so long products stay finite, plus raw patterns.
  function automatic logic [31:0] rand_element();
    logic [31:0] specials [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                  32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001,
                                  32'h7F7F_FFFF, 32'h0080_0000};
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return specials[$urandom_range(0, 7)];
      default: return {1'($urandom), 8'($urandom_range(124, 130)), 23'($urandom)};
    endcase
  endfunction

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Send one request; valid stays high into the next request unless a gap or the mid-run drain comes.
  task automatic send_element(logic [31:0] value);
    if (!calm && gap_mode && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= value;
    do @(negedge clk); while (!req_ch.ready);
    @(posedge clk);
    sent++;
    if (!drained_once && sent == ITEM_TARGET / 2) begin
      drained_once = 1'b1;
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clk);
    end
  endtask

  // Write all three registers, one per cycle, in random order, with the block idle.
  task automatic set_matrix(logic [10:0] win, logic [10:0] rows, logic [10:0] cols);
    logic [1:0]  order [3] = '{REG_WINDOW, REG_ROWS, REG_COLS};
    logic [10:0] val;
    int          pick;
    logic [1:0]  tmp;
    req_ch.valid <= 1'b0;
    wait_drained();
    for (int i = 2; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end
    for (int i = 0; i < 3; i++) begin
      case (order[i])
        REG_WINDOW: val = win;
        REG_ROWS:   val = rows;
        default:    val = cols;
      endcase
      cfg_we <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int k, rows, cols, count;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes: a few elements of a huge matrix, no window completes.
    repeat (3) send_element(rand_element());

    // One by one window: each element times one, specials and NaN folding.
    set_matrix(11'd0, 11'd2, 11'd3);
    send_element(32'h0000_0000);
    send_element(32'h8000_0000);
    send_element(32'h7F80_0000);
    send_element(32'hFF80_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'h7F7F_FFFF);

    // Two by two: infinity times zero, zero products and overflow.
    set_matrix(11'd2, 11'd3, 11'd3);
    send_element(32'h7F80_0000);
    send_element(32'h0000_0000);
    send_element(32'h0080_0000);
    send_element(32'h7F7F_FFFF);
    send_element(32'h7F7F_FFFF);
    send_element(32'h3F00_0001);
    send_element(32'h0000_0001);
    send_element(32'h3EFF_FFFF);
    send_element(32'hBF80_0000);

    // Oversized window: saturated size, zero rows, columns past the limit.
    set_matrix(11'd15, 11'd0, 11'd2047);
    repeat (4) send_element(rand_element());

    // Random matrices, mostly complete ones with random contents.
    while (sent < ITEM_TARGET) begin
      k = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 8);
      rows = k + $urandom_range(0, 3);
      cols = k + $urandom_range(0, 5);
      if (k > 1 && $urandom_range(0, 9) == 0) rows = $urandom_range(1, k - 1);
      if (k > 1 && $urandom_range(0, 9) == 0) cols = $urandom_range(1, k - 1);
      stall_mode = $urandom_range(0, 3) != 0;
      gap_mode = $urandom_range(0, 3) != 0;
      set_matrix((k == 1 && $urandom_range(0, 1)) ? 11'd0 : 11'(k), 11'(rows), 11'(cols));
      count = rows * cols * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) count += $urandom_range(0, cols);
      // Keep the total close to the target.
      if (count > ITEM_TARGET - sent) count = ITEM_TARGET - sent;
      repeat (count) begin
        if (sent >= CALM_AFTER) calm = 1'b1;
        send_element(rand_element());
      end
    end
    req_ch.valid <= 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("tb_sliding_window_product OK");
    end else begin
      $display("tb_sliding_window_product NOT OK");
    end
    $finish;
  end

endmodule

/* sliding_window_product.f */
rtl/core/swp_pkg.sv
rtl/core/swp_if.sv
rtl/core/swp_fmul.sv
rtl/core/swp_seq.sv
rtl/core/sliding_window_product.sv
dv/swp_tb_checker.sv
dv/tb_sliding_window_product.sv
